// File: design/olt_pkg.sv
package olt_pkg;

	// default list depth
	localparam int unsigned CAPACITY_DEF = 64;

	// fixed field widths
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned FPOS_W   = 6;
	localparam int unsigned COUNT_W  = 7;

	// request codes; the unused code falls to the default arm
	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_GET    = 3'd1,
		REQ_SET    = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_FIND   = 3'd4,
		REQ_FILL   = 3'd5,
		REQ_SIZE   = 3'd6
	} req_code_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GET,
		S_SHIFT,
		S_SCAN,
		S_FILL,
		S_RESP
	} olt_state_t;

	// request word
	typedef struct packed {
		logic [2:0]          req_type;
		logic [POS_W-1:0]    position;
		logic [HANDLE_W-1:0] handle;
	} req_word_t;

	// response word
	typedef struct packed {
		logic [HANDLE_W-1:0] read_value;
		logic [FPOS_W-1:0]   found_position;
		logic [1:0]          status;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_word_t;

endpackage

// File: design/olt_ram.sv
module olt_ram #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [olt_pkg::HANDLE_W-1:0]      wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic [olt_pkg::HANDLE_W-1:0]      rdata
);
	import olt_pkg::*;

	logic [HANDLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/olt_ctrl.sv
module olt_ctrl #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  olt_pkg::req_word_t                req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output olt_pkg::rsp_word_t                rsp,
	output logic                              mem_we,
	output logic [$clog2(CAPACITY)-1:0]       mem_waddr,
	output logic [olt_pkg::HANDLE_W-1:0]      mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(CAPACITY)-1:0]       mem_raddr,
	input  logic [olt_pkg::HANDLE_W-1:0]      mem_rdata
);
	import olt_pkg::*;

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned XW   = CMPW + 1;
	localparam int unsigned EW   = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int unsigned FW   = (AW > FPOS_W) ? AW : FPOS_W;

	olt_state_t          state_q, state_d;
	req_word_t           req_q;
	logic                req_ld;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [HANDLE_W-1:0] rd_q, rd_d;
	logic [AW-1:0]       fpos_q, fpos_d;
	status_t             st_q, st_d;
	logic                rsp_ld;
	logic                rsp_valid_q;
	rsp_word_t           rsp_q;

	logic [CMPW-1:0]     pos_ext;
	logic                pos_ok;
	logic [AW-1:0]       pos_a;
	logic [EW-1:0]       cnt_ext;
	logic [FW-1:0]       fpos_ext;

	// index checks against the count
	assign pos_ext  = CMPW'(req.position);
	assign pos_ok   = pos_ext < CMPW'(count_q);
	assign pos_a    = pos_ext[AW-1:0];
	assign cnt_ext  = EW'(count_q);
	assign fpos_ext = FW'(fpos_q);

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (req_ld) begin
			req_q <= req;
		end
		idx_q  <= idx_d;
		rd_q   <= rd_d;
		fpos_q <= fpos_d;
		st_q   <= st_d;
	end

	// sequence each request through the memory
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		rd_d      = rd_q;
		fpos_d    = fpos_q;
		st_d      = st_q;
		req_ld    = 1'b0;
		req_ready = 1'b0;
		rsp_ld    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = req_q.handle;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_ld  = 1'b1;
					rd_d    = '0;
					fpos_d  = '0;
					st_d    = ST_OK;
					state_d = S_RESP;
					case (req.req_type)
						REQ_APPEND: begin
							if (count_q == CW'(CAPACITY)) begin
								st_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = req.handle;
								count_d   = count_q + CW'(1);
							end
						end
						REQ_GET: begin
							if (pos_ok) begin
								mem_re    = 1'b1;
								mem_raddr = pos_a;
								state_d   = S_GET;
							end else begin
								st_d = ST_RANGE;
							end
						end
						REQ_SET: begin
							if (pos_ok) begin
								mem_we    = 1'b1;
								mem_waddr = pos_a;
								mem_wdata = req.handle;
							end else begin
								st_d = ST_RANGE;
							end
						end
						REQ_REMOVE: begin
							if (pos_ok) begin
								idx_d = pos_a;
								if (XW'(pos_ext) + XW'(1) < XW'(count_q)) begin
									mem_re    = 1'b1;
									mem_raddr = pos_a + AW'(1);
									state_d   = S_SHIFT;
								end else begin
									count_d = count_q - CW'(1);
								end
							end else begin
								st_d = ST_RANGE;
							end
						end
						REQ_FIND: begin
							if (count_q == '0) begin
								st_d = ST_NOTFOUND;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						REQ_FILL: begin
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = req.handle;
							idx_d     = AW'(1);
							state_d   = S_FILL;
						end
						default: begin
						end
					endcase
				end
			end
			S_GET: begin
				rd_d    = mem_rdata;
				state_d = S_RESP;
			end
			S_SHIFT: begin
				// move the word above down by one slot
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				idx_d     = idx_q + AW'(1);
				if (XW'(idx_q) + XW'(2) < XW'(count_q)) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(2);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (mem_rdata == req_q.handle) begin
					fpos_d  = idx_q;
					state_d = S_RESP;
				end else if (XW'(idx_q) + XW'(1) < XW'(count_q)) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_d     = idx_q + AW'(1);
				end else begin
					st_d    = ST_NOTFOUND;
					state_d = S_RESP;
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = req_q.handle;
				if (idx_q == AW'(CAPACITY - 1)) begin
					count_d = CW'(CAPACITY);
					state_d = S_RESP;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			S_RESP: begin
				// hand over once the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_q.read_value     <= rd_q;
			rsp_q.found_position <= fpos_ext[FPOS_W-1:0];
			rsp_q.status         <= st_q;
			rsp_q.entry_count    <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/ordered_list_table.sv
// Sequence: size, append, set and rejected requests go straight to the response state;
// get reads the entry first; find reads up to count entries (one memory read per entry scanned);
// remove moves the entries above position down (one entry moved per cycle); fill writes every slot.
// One word in flight; the next word is taken in the cycle after the response
// enters the output register, and a response waits in S_RESP while the held one is not taken.
// Reset: arst_n clears the count and control; the entry RAM is not cleared.
module ordered_list_table #(
	parameter int unsigned CAPACITY = olt_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  olt_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output olt_pkg::rsp_word_t rsp
);
	import olt_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [HANDLE_W-1:0] mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [HANDLE_W-1:0] mem_rdata;

	// request sequencer and output register
	olt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// entry store
	olt_ram #(
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// File: design/olt_checker.sv
module olt_checker #(
	parameter int unsigned CAPACITY = olt_pkg::CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input olt_pkg::req_word_t req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input olt_pkg::rsp_word_t rsp
);
	import olt_pkg::*;

	localparam bit NARROW = CAPACITY < 128;

	// hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// take one word at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// zero payload on failed requests
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0 && rsp.found_position == '0)
		else $error("failed request carries a payload");

	// report full only at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL && NARROW |-> rsp.entry_count == COUNT_W'(CAPACITY))
		else $error("list full reported below capacity");

	// never exceed capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW |-> rsp.entry_count <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

endmodule

bind ordered_list_table olt_checker #(.CAPACITY(CAPACITY)) u_chk (.*);
